// ===== rtl/ucd_pkg.sv =====
// Shared types, constants and byte-class functions of the UTF-8 code point decoder.
// Depends on nothing; used by every module of the block by scoped names.
package ucd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned CNT_W   = 2;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned SEQ_MAX = 4;
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = 1;
  localparam int unsigned QCNT_W  = 2;

  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_VAL  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_VAL  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_VAL  = 8'hF0;

  localparam logic [LEN_W-1:0] LEN1 = 3'd1;
  localparam logic [LEN_W-1:0] LEN2 = 3'd2;
  localparam logic [LEN_W-1:0] LEN3 = 3'd3;
  localparam logic [LEN_W-1:0] LEN4 = 3'd4;

  typedef struct packed {
    logic [SEQ_MAX-1:0][BYTE_W-1:0] bytes;
    logic [LEN_W-1:0]               n;
    logic                           fin;
  } ucd_entry_t;

  function automatic logic [LEN_W-1:0] seq_length(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] len;
    if ((b & LEAD2_MASK) == LEAD2_VAL) len = LEN2;
    else if ((b & LEAD3_MASK) == LEAD3_VAL) len = LEN3;
    else if ((b & LEAD4_MASK) == LEAD4_VAL) len = LEN4;
    else len = LEN1;
    return len;
  endfunction

  function automatic logic [CP_W-1:0] decode_seq(
    input logic [SEQ_MAX-1:0][BYTE_W-1:0] s,
    input logic [LEN_W-1:0]               len
  );
    logic [CP_W-1:0] cp;
    unique case (len)
      LEN2:    cp = {10'd0, s[0][4:0], s[1][5:0]};
      LEN3:    cp = {5'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
      LEN4:    cp = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
      default: cp = {13'd0, s[0]};
    endcase
    return cp;
  endfunction

endpackage

// ===== rtl/ucd_front.sv =====
// Front part: takes text bytes, holds the bytes of an open sequence and
// pushes a finished sequence or the end-of-text flush to the queue. Uses ucd_pkg.
module ucd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [ucd_pkg::BYTE_W-1:0]   text_byte,
  input  logic                         final_byte,
  output logic                         q_push,
  output ucd_pkg::ucd_entry_t          q_entry
);

  logic [ucd_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [2:0][ucd_pkg::BYTE_W-1:0] pend_r;
  logic [ucd_pkg::BYTE_W-1:0] lead;
  logic [ucd_pkg::LEN_W-1:0]  n;
  logic                       complete;

  always_comb begin
    for (int k = 0; k < ucd_pkg::SEQ_MAX - 1; k++) begin
      q_entry.bytes[k] = (k == int'(count_r)) ? text_byte : pend_r[k];
    end
    q_entry.bytes[ucd_pkg::SEQ_MAX-1] = text_byte;
    n        = {1'b0, count_r} + ucd_pkg::LEN1;
    lead     = (count_r == '0) ? text_byte : pend_r[0];
    complete = ucd_pkg::seq_length(lead) <= n;
    q_entry.n   = n;
    q_entry.fin = final_byte;
    q_push      = push && (final_byte || complete);
    count_nxt   = count_r;
    if (push) begin
      if (final_byte || complete) count_nxt = '0;
      else count_nxt = count_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // hold the byte of an open sequence
  always_ff @(posedge clk) begin
    if (push && !final_byte && !complete) begin
      pend_r[count_r] <= text_byte;
    end
  end

endmodule

// ===== rtl/ucd_queue.sv =====
// Two-entry queue of sequence jobs between front and back parts.
// Uses ucd_pkg for the entry type and depth.
module ucd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr,
  input  ucd_pkg::ucd_entry_t wr_data,
  input  logic                rd,
  output ucd_pkg::ucd_entry_t rd_data,
  output logic                q_valid,
  output logic                q_full
);

  ucd_pkg::ucd_entry_t             slot_r [ucd_pkg::QDEPTH];
  logic [ucd_pkg::QPTR_W-1:0]      wptr_r, rptr_r;
  logic [ucd_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;

  assign rd_data = slot_r[rptr_r];
  assign q_valid = cnt_r != '0;
  assign q_full  = cnt_r == ucd_pkg::QCNT_W'(ucd_pkg::QDEPTH);

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !rd) cnt_nxt = cnt_r + 2'd1;
    else if (rd && !wr) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr) wptr_r <= wptr_r + 1'b1;
      if (rd) rptr_r <= rptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/ucd_back.sv =====
// Back part: walks one queued job, one code point per beat, shifting out
// consumed bytes; raw lead when a sequence does not fit. Uses ucd_pkg.
module ucd_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  ucd_pkg::ucd_entry_t        q_entry,
  output logic                       q_rd,
  input  logic                       pop,
  output logic                       empty,
  output logic [ucd_pkg::CP_W-1:0]   code_point,
  output logic                       run_last,
  output logic                       text_done
);

  logic                      valid_r, valid_nxt;
  ucd_pkg::ucd_entry_t       work_r, work_nxt;
  logic [ucd_pkg::LEN_W-1:0] len, use_len;
  logic                      last;

  always_comb begin
    len     = ucd_pkg::seq_length(work_r.bytes[0]);
    use_len = (len <= work_r.n) ? len : ucd_pkg::LEN1;
    last    = work_r.n == use_len;
    code_point = ucd_pkg::decode_seq(work_r.bytes, use_len);
    run_last   = last;
    text_done  = last && work_r.fin;
    empty      = !valid_r;
    q_rd       = q_valid && (!valid_r || (pop && last));
    valid_nxt  = valid_r;
    work_nxt   = work_r;
    if (q_rd) begin
      valid_nxt = 1'b1;
      work_nxt  = q_entry;
    end else if (valid_r && pop) begin
      if (last) begin
        valid_nxt = 1'b0;
      end else begin
        // advance past the consumed bytes
        work_nxt.bytes = work_r.bytes >> {use_len, 3'b000};
        work_nxt.n     = work_r.n - use_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

endmodule

// ===== rtl/utf8_codepoint_decoder.sv =====
// UTF-8 code point decoder, top level: front, job queue and back part.
// A result goes through a queue slot and the back part's work register to the out_ ports.
// Throughput: one byte per cycle while full is low; a final byte in an open sequence
// flushes up to three results, one per popped cycle, as the back part has one output.
// Reset (rst_n low, synchronous) drops held bytes and empties queue and output.
module utf8_codepoint_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [ucd_pkg::BYTE_W-1:0]   in_text_byte,
  input  logic                         in_final_byte,
  output logic                         empty,
  input  logic                         pop,
  output logic [ucd_pkg::CP_W-1:0]     out_code_point,
  output logic                         out_run_last,
  output logic                         out_text_done
);

  logic                q_push, q_rd, q_valid, q_full;
  ucd_pkg::ucd_entry_t f_entry, q_head;

  assign full = q_full;

  ucd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push && !q_full),
    .text_byte  (in_text_byte),
    .final_byte (in_final_byte),
    .q_push     (q_push),
    .q_entry    (f_entry)
  );

  ucd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_push),
    .wr_data (f_entry),
    .rd      (q_rd),
    .rd_data (q_head),
    .q_valid (q_valid),
    .q_full  (q_full)
  );

  ucd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (q_head),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .code_point (out_code_point),
    .run_last   (out_run_last),
    .text_done  (out_text_done)
  );

endmodule
